// File: rtl/move_to_front_list_top_assert.svh
// Assertion macros shared by the move-to-front list checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MOVE_TO_FRONT_LIST_TOP_ASSERT_SVH
`define MOVE_TO_FRONT_LIST_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define MTF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define MTF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mtf_pkg.sv
// Shared constants, types and cell link structs for the move-to-front list.
// No dependencies.
package mtf_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int VALUE_W    = 32;
    localparam int HIT_POS_W  = 4;
    localparam int COUNT_W    = 5;

    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [HIT_POS_W-1:0]      hit_pos_t;
    typedef logic [COUNT_W-1:0]        count_t;

    typedef enum logic
    {
        MODE_INSERT = 1'b0,
        MODE_FIND   = 1'b1
    } mode_t;

    // Data handed from one cell to the next one toward the back
    typedef struct packed
    {
        value_t entry;
        logic   valid;
        logic   hit;
        idx_t   pos;
    } cell_link_t;

    // Control broadcast from the sequencer to every cell
    typedef struct packed
    {
        logic   capture;
        value_t cmp_value;
        logic   upd_insert;
        logic   upd_find;
        logic   found;
    } cell_ctl_t;

endpackage

// File: rtl/mtf_if.sv
// Request and response channel interfaces for the move-to-front list.
// Depends on mtf_pkg.
interface mtf_req_if;
    import mtf_pkg::*;

    logic   valid;
    logic   ready;
    logic   mode;
    value_t value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface mtf_rsp_if;
    import mtf_pkg::*;

    logic     valid;
    logic     ready;
    logic     found;
    hit_pos_t hit_position;
    count_t   entry_count;

    modport source (output valid, output found, output hit_position, output entry_count,
                    input ready);
    modport sink   (input valid, input found, input hit_position, input entry_count,
                    output ready);
endinterface

// File: rtl/mtf_cell.sv
// One list cell: holds an entry and its valid bit, compares, shifts from its neighbor.
// Depends on mtf_pkg.
module mtf_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  mtf_pkg::idx_t      idx,
    input  mtf_pkg::cell_ctl_t ctl,
    input  mtf_pkg::cell_link_t link_in,
    output mtf_pkg::cell_link_t link_out
);
    import mtf_pkg::*;

    value_t entry_reg;
    logic   valid_reg;
    logic   match_reg;
    logic   first_hit;
    logic   shift_en;

    // Registered compare against the request value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            match_reg <= valid_reg && (entry_reg == ctl.cmp_value);
        end
    end

    // Cells at or ahead of the hit take their neighbor's entry; insert shifts all
    assign shift_en = ctl.upd_insert || (ctl.upd_find && ctl.found && !link_in.hit);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.upd_insert)
        begin
            valid_reg <= link_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= link_in.entry;
        end
    end

    // First-match chain toward the back
    assign first_hit      = match_reg && !link_in.hit;
    assign link_out.entry = entry_reg;
    assign link_out.valid = valid_reg;
    assign link_out.hit   = link_in.hit || match_reg;
    assign link_out.pos   = link_in.pos | (first_hit ? idx : '0);

endmodule

// File: rtl/move_to_front_list_top.sv
// Move-to-front list: LIST_DEPTH cells in a row with a two-step sequencer.
// A request is compared in the cells as it is accepted; its update then waits until
// the response register is free, and a new request is taken only after that update.
// Reset clears all valid bits, the entry count and the response valid flag;
// entry contents are not cleared and are never read before being written.
// Depends on mtf_pkg, mtf_req_if, mtf_rsp_if and mtf_cell.
module move_to_front_list_top
(
    input  logic   clk,
    input  logic   rst_n,
    mtf_req_if.sink   in_req,
    mtf_rsp_if.source out_rsp
);
    import mtf_pkg::*;

    typedef enum logic [1:0]
    {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t     state_reg, state_next;
    logic       mode_reg;
    value_t     value_reg;
    cnt_t       count_reg, count_next;
    logic       out_valid_reg;
    logic       found_reg;
    hit_pos_t   pos_reg;
    count_t     count_out_reg;

    logic       accept;
    logic       upd;
    logic       found;
    cell_ctl_t  ctl;
    cell_link_t links [LIST_DEPTH+1];
    logic [IDX_W+HIT_POS_W-1:0] pos_wide;
    logic [CNT_W+COUNT_W-1:0]   count_wide;

    // Handshake
    assign in_req.ready = (state_reg == ST_IDLE);
    assign accept       = in_req.valid && in_req.ready;
    assign upd          = (state_reg == ST_UPDATE) && (!out_valid_reg || out_rsp.ready);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (upd)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= in_req.mode;
            value_reg <= in_req.value;
        end
    end

    // Cell control
    assign ctl.capture    = accept;
    assign ctl.cmp_value  = in_req.value;
    assign ctl.upd_insert = upd && (mode_reg == MODE_INSERT);
    assign ctl.upd_find   = upd && (mode_reg == MODE_FIND);
    assign ctl.found      = found;

    // Front of the chain feeds the request value
    assign links[0].entry = value_reg;
    assign links[0].valid = 1'b1;
    assign links[0].hit   = 1'b0;
    assign links[0].pos   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_cell
            mtf_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .idx      (IDX_W'(gi)),
                .ctl      (ctl),
                .link_in  (links[gi]),
                .link_out (links[gi+1])
            );
        end
    endgenerate

    assign found = (mode_reg == MODE_FIND) && links[LIST_DEPTH].hit;

    // Entry count, saturating on insert
    always_comb
    begin
        count_next = count_reg;
        if (ctl.upd_insert && (count_reg != CNT_W'(LIST_DEPTH)))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Fit internal widths to the response fields
    assign pos_wide   = {{HIT_POS_W{1'b0}}, (found ? links[LIST_DEPTH].pos : idx_t'(0))};
    assign count_wide = {{COUNT_W{1'b0}}, count_next};

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (upd)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            found_reg     <= found;
            pos_reg       <= pos_wide[HIT_POS_W-1:0];
            count_out_reg <= count_wide[COUNT_W-1:0];
        end
    end

    assign out_rsp.valid        = out_valid_reg;
    assign out_rsp.found        = found_reg;
    assign out_rsp.hit_position = pos_reg;
    assign out_rsp.entry_count  = count_out_reg;

endmodule

// File: rtl/mtf_checker.sv
// Port-level checks for the move-to-front list, bound to the top level.
// Depends on move_to_front_list_top_assert.svh and move_to_front_list_top.
`include "move_to_front_list_top_assert.svh"

module mtf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       found,
    input logic [3:0] hit_position,
    input logic [4:0] entry_count
);

    // One request in flight: no accept right after an accept
    `MTF_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "request accepted while busy")

    // A miss or insert reports position zero
    `MTF_ASSERT_NOW(a_miss_pos_zero, clk, rst_n, out_valid && !found, hit_position == 4'd0, "nonzero position without hit")

    // A hit lies inside the valid entries
    `MTF_ASSERT_NOW(a_hit_in_range, clk, rst_n, out_valid && found, {1'b0, hit_position} < entry_count, "hit beyond entry count")

    // A stalled response holds
    `MTF_ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(found) && $stable(hit_position) && $stable(entry_count), "stalled response changed")

endmodule

bind move_to_front_list_top mtf_checker u_mtf_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_req.valid),
    .in_ready     (in_req.ready),
    .out_valid    (out_rsp.valid),
    .out_ready    (out_rsp.ready),
    .found        (out_rsp.found),
    .hit_position (out_rsp.hit_position),
    .entry_count  (out_rsp.entry_count)
);
